// ===== hw/rtl/multi_server_queue_dispatcher_unit_assert.svh =====
// assertion macros for the queue dispatcher
`ifndef MULTI_SERVER_QUEUE_DISPATCHER_UNIT_ASSERT_SVH
`define MULTI_SERVER_QUEUE_DISPATCHER_UNIT_ASSERT_SVH
// implication check on clk, disabled in reset
`define MSQD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication check on clk, disabled in reset
`define MSQD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/msqd_pkg.sv =====
// package: constants, types and command struct for the queue dispatcher
`default_nettype none
package msqd_pkg;
  localparam int MAX_SERVERS = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int SW = $clog2(MAX_SERVERS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = QW + 1;

  localparam logic [1:0] KIND_DEPART = 2'd0;
  localparam logic [1:0] KIND_SERVE = 2'd1;
  localparam logic [1:0] KIND_SNAP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REL, ST_ASG_RD, ST_ASG, ST_SNAP, ST_OUT
  } state_t;

  typedef struct packed {
    logic take_in;
    logic clr_slot;
    logic inc_slot;
    logic release_slot;
    logic fifo_rd;
    logic assign_slot;
    logic emit;
    logic [1:0] emit_kind;
    logic snap;
    logic end_tick;
  } cmd_t;

  typedef struct packed {
    logic slot_last;
    logic slot_done;
    logic slot_free;
    logic fifo_empty;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/msqd_ctrl.sv =====
// controller state machine of the queue dispatcher
`default_nettype none
module msqd_ctrl import msqd_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         out_busy,
  input  stat_t       stat,
  output cmd_t        cmd
);
  state_t state, state_next;
  state_t ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret <= ST_IDLE;
    end else begin
      state <= state_next;
      ret <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next = ret;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          cmd.clr_slot = 1'b1;
          state_next = ST_REL;
        end
      end
      ST_REL: begin
        if (stat.slot_done) begin
          cmd.release_slot = 1'b1;
          cmd.emit = 1'b1;
          cmd.emit_kind = KIND_DEPART;
          ret_next = stat.slot_last ? ST_ASG_RD : ST_REL;
          if (stat.slot_last) cmd.clr_slot = 1'b1;
          else cmd.inc_slot = 1'b1;
          state_next = ST_OUT;
        end else if (stat.slot_last) begin
          cmd.clr_slot = 1'b1;
          state_next = ST_ASG_RD;
        end else begin
          cmd.inc_slot = 1'b1;
        end
      end
      ST_ASG_RD: begin
        if (stat.slot_free && !stat.fifo_empty) begin
          cmd.fifo_rd = 1'b1;
          state_next = ST_ASG;
        end else if (stat.slot_last) begin
          state_next = ST_SNAP;
        end else begin
          cmd.inc_slot = 1'b1;
        end
      end
      ST_ASG: begin
        cmd.assign_slot = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_kind = KIND_SERVE;
        ret_next = stat.slot_last ? ST_SNAP : ST_ASG_RD;
        if (!stat.slot_last) cmd.inc_slot = 1'b1;
        state_next = ST_OUT;
      end
      ST_SNAP: begin
        cmd.snap = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_kind = KIND_SNAP;
        cmd.end_tick = 1'b1;
        ret_next = ST_IDLE;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) state_next = ret;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/msqd_datapath.sv =====
// datapath: fifo memory, slot records, totals and output register
`default_nettype none
module msqd_datapath import msqd_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [3:0]  cfg_data,
  input  wire         in_arrive,
  input  wire  [5:0]  in_svc,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_busy,
  output logic        m_valid,
  input  wire         m_ready,
  output logic [1:0]  o_kind,
  output logic [2:0]  o_server,
  output logic [15:0] o_id,
  output logic [15:0] o_wait,
  output logic [6:0]  o_qlen,
  output logic [31:0] o_arr,
  output logic [31:0] o_srv,
  output logic [31:0] o_wsum,
  output logic [31:0] o_ssum,
  output logic [31:0] o_qsum,
  output logic [6:0]  o_max
);
  logic [37:0] mem [QUEUE_DEPTH];
  logic [37:0] rd;
  logic [QW-1:0] head;
  logic [CW-1:0] count;
  logic [3:0] nsrv;
  logic [SW-1:0] sidx;
  logic [SW:0] used;
  logic [MAX_SERVERS-1:0] busy;
  logic [15:0] s_id [MAX_SERVERS];
  logic [15:0] s_wait [MAX_SERVERS];
  logic [5:0] s_svc [MAX_SERVERS];
  logic [15:0] s_fin [MAX_SERVERS];
  logic [15:0] tick, next_id;
  logic [31:0] t_arr, t_srv, t_wsum, t_ssum, t_qsum;
  logic [CW-1:0] peak;
  logic [15:0] diff, rd_wait;

  always_comb begin
    if (nsrv == 4'd0) used = (SW+1)'(1);
    else if (32'(nsrv) > MAX_SERVERS) used = (SW+1)'(MAX_SERVERS);
    else used = (SW+1)'(nsrv);
  end
  assign diff = tick - s_fin[sidx];
  assign rd_wait = tick - rd[37:22];
  assign stat.slot_last = ({1'b0, sidx} == used - (SW+1)'(1));
  assign stat.slot_done = busy[sidx] && !diff[15];
  assign stat.slot_free = !busy[sidx];
  assign stat.fifo_empty = (count == '0);
  assign out_busy = m_valid && !m_ready;

  always_ff @(posedge clk) begin
    if (in_arrive && cmd.take_in && 32'(count) < QUEUE_DEPTH)
      mem[QW'(32'(head) + 32'(count))] <= {tick, next_id, in_svc};
    if (cmd.fifo_rd) rd <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nsrv <= 4'd2; head <= '0; count <= '0; sidx <= '0; busy <= '0;
      tick <= '0; next_id <= 16'd1; t_arr <= '0; t_srv <= '0;
      t_wsum <= '0; t_ssum <= '0; t_qsum <= '0; peak <= '0; m_valid <= 1'b0;
    end else begin
      if (cfg_we) nsrv <= cfg_data;
      if (m_valid && m_ready) m_valid <= 1'b0;
      if (cmd.take_in && in_arrive && 32'(count) < QUEUE_DEPTH) begin
        count <= count + CW'(1);
        next_id <= next_id + 16'd1;
        t_arr <= t_arr + 32'd1;
      end
      if (cmd.clr_slot) sidx <= '0;
      else if (cmd.inc_slot) sidx <= sidx + SW'(1);
      if (cmd.release_slot) begin
        busy[sidx] <= 1'b0;
        t_srv <= t_srv + 32'd1;
        t_wsum <= t_wsum + 32'(s_wait[sidx]);
        t_ssum <= t_ssum + 32'(s_svc[sidx]);
      end
      if (cmd.fifo_rd) begin
        head <= head + QW'(1);
        count <= count - CW'(1);
      end
      if (cmd.assign_slot) busy[sidx] <= 1'b1;
      if (cmd.snap) begin
        t_qsum <= t_qsum + 32'(count);
        if (count > peak) peak <= count;
      end
      if (cmd.end_tick) tick <= tick + 16'd1;
      if (cmd.emit) m_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.assign_slot) begin
      s_id[sidx] <= rd[21:6];
      s_svc[sidx] <= rd[5:0];
      s_wait[sidx] <= rd_wait;
      s_fin[sidx] <= tick + 16'(rd[5:0]);
    end
    if (cmd.emit) begin
      o_kind <= cmd.emit_kind;
      o_server <= '0; o_id <= '0; o_wait <= '0; o_qlen <= '0; o_arr <= '0;
      o_srv <= '0; o_wsum <= '0; o_ssum <= '0; o_qsum <= '0; o_max <= '0;
      if (cmd.release_slot) begin
        o_server <= 3'(sidx); o_id <= s_id[sidx]; o_wait <= s_wait[sidx];
      end
      if (cmd.assign_slot) begin
        o_server <= 3'(sidx); o_id <= rd[21:6]; o_wait <= rd_wait;
      end
      if (cmd.snap) begin
        o_qlen <= 7'(count); o_arr <= t_arr; o_srv <= t_srv; o_wsum <= t_wsum;
        o_ssum <= t_ssum; o_qsum <= t_qsum + 32'(count);
        o_max <= (count > peak) ? 7'(count) : 7'(peak);
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/multi_server_queue_dispatcher_unit.sv =====
// top level of the multi-server queue dispatcher
// One input item is one simulation tick. The block processes one tick at a time:
// after acceptance it walks the active server slots once for releases and once for
// assignments, one slot per cycle while no item is emitted and no receiver stall holds
// the walk, and emits up to 17 result items through a single output register. Each
// serve item takes a fifo read step and then an assign step, and each emitted item
// waits in the one-entry output register until the receiver takes it before the walk
// goes on. Waiting customers sit in a 64-entry memory with a registered read port.
// No clearing pass is needed.
`default_nettype none
module multi_server_queue_dispatcher_unit import msqd_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [3:0]   cfg_data,      // num_servers
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,       // arrive, service_time[6:1], zero pad
  output logic         m_tvalid,
  input  wire          m_tready,
  // server[2:0], customer_id, wait_time, queue_length, arrived_total, served_total,
  // wait_total, service_total, queue_length_sum, max_queue, zero pad
  output logic [215:0] m_tdata,
  output logic [1:0]   m_tuser,       // kind
  output logic         m_tlast        // last
);
  cmd_t cmd;
  stat_t stat;
  logic out_busy;
  logic [1:0] kind;
  logic [2:0] srv;
  logic [15:0] id, wt;
  logic [6:0] ql, mx;
  logic [31:0] a, b, c, d, e;

  // sequencer
  msqd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_busy(out_busy), .stat(stat), .cmd(cmd)
  );

  // storage and arithmetic
  msqd_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_arrive(s_tdata[0]), .in_svc(s_tdata[6:1]), .cmd(cmd), .stat(stat),
    .out_busy(out_busy), .m_valid(m_tvalid), .m_ready(m_tready),
    .o_kind(kind), .o_server(srv), .o_id(id), .o_wait(wt), .o_qlen(ql),
    .o_arr(a), .o_srv(b), .o_wsum(c), .o_ssum(d), .o_qsum(e), .o_max(mx)
  );

  assign m_tuser = kind;
  assign m_tlast = (kind == KIND_SNAP);
  assign m_tdata = {7'd0, mx, e, d, c, b, a, ql, wt, id, srv};
endmodule
`default_nettype wire

// ===== hw/rtl/msqd_checker.sv =====
// port-level checker for the queue dispatcher, bound to the top level
`default_nettype none
`include "multi_server_queue_dispatcher_unit_assert.svh"
module msqd_checker import msqd_pkg::*; (
  input wire         clk,
  input wire         rst,
  input wire         s_tvalid,
  input wire         s_tready,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [1:0]   m_tuser,
  input wire         m_tlast,
  input wire [215:0] m_tdata
);
  `MSQD_ASSERT_IMP(a_last_kind, m_tvalid, m_tlast == (m_tuser == KIND_SNAP), "last mismatch")
  `MSQD_ASSERT_IMP(a_kind_range, m_tvalid, m_tuser <= KIND_SNAP, "bad kind")
  `MSQD_ASSERT_NXT(a_no_take, s_tvalid && s_tready, !s_tready, "took two ticks")
  `MSQD_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "item dropped")
endmodule
bind multi_server_queue_dispatcher_unit msqd_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser),
  .m_tlast(m_tlast), .m_tdata(m_tdata)
);
`default_nettype wire
